// File: sv/sfdop_pkg.sv
// Shared types and constants for the sample queue with drop-oldest overflow.
package sfdop_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FILL_W    = 13;
  localparam int TOTAL_W   = 32;
  localparam int LIMIT_W   = 13;
  localparam int CHUNK_W   = 7;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 13;
  localparam int OUT_TDATA_W = 112;

  // Command codes carried in the input tuser.
  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATS = 2'd2;

  // Result kinds carried in the output tuser.
  localparam logic KIND_POP   = 1'b0;
  localparam logic KIND_STATS = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LEN   = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic do_push;
    logic pop_start;
    logic rd_issue;
    logic out_pop;
    logic pop_done;
    logic out_fail;
    logic out_stats;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CMD_W-1:0] cmd_code;
    logic             pop_ok;
    logic             pop_last;
    logic             out_free;
  } dp_sts_t;

endpackage

// File: sv/sfdop_ctrl.sv
// Sequencing state machine for the sample queue.
module sfdop_ctrl
  import sfdop_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DISP    = 3'd1;
  localparam logic [2:0] ST_FAIL    = 3'd2;
  localparam logic [2:0] ST_STATS   = 3'd3;
  localparam logic [2:0] ST_POP_RD  = 3'd4;
  localparam logic [2:0] ST_POP_OUT = 3'd5;

  logic [2:0] state_q, state_d;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.cmd_code)
          CMD_PUSH: begin
            cmd_o.do_push = 1'b1;
            state_d       = ST_IDLE;
          end
          CMD_POP: begin
            if (sts_i.pop_ok) begin
              cmd_o.pop_start = 1'b1;
              state_d         = ST_POP_RD;
            end else begin
              state_d = ST_FAIL;
            end
          end
          CMD_STATS: state_d = ST_STATS;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_FAIL: begin
        if (sts_i.out_free) begin
          cmd_o.out_fail = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_STATS: begin
        if (sts_i.out_free) begin
          cmd_o.out_stats = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_POP_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_pop = 1'b1;
          if (sts_i.pop_last) begin
            cmd_o.pop_done = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            state_d = ST_POP_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // At most one result is loaded per cycle, and only into a free output register.
  a_one_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.out_pop, cmd_o.out_fail, cmd_o.out_stats}))
    else $error("more than one result loaded in a cycle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_pop || cmd_o.out_fail || cmd_o.out_stats) |-> sts_i.out_free)
    else $error("result loaded over a waiting word");

  // An input word is captured only on a completed handshake.
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_in |-> (s_axis_tvalid && s_axis_tready))
    else $error("input word loaded without a handshake");

endmodule

// File: sv/sfdop_dpath.sv
// Ring storage, counters, peak meter and output register of the sample queue.
module sfdop_dpath
  import sfdop_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int MAX_CHUNK = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [CMD_W-1:0]            in_cmd_i,
  input  logic signed [SAMPLE_W-1:0]  in_sample_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DAT_W-1:0]        cfg_data_i,
  input  ctrl_cmd_t                   cmd_i,
  output dp_sts_t                     sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_kind_o,
  output logic                        out_last_o,
  output logic [OUT_TDATA_W-1:0]      out_data_o
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = ((AW > FILL_W) ? AW : FILL_W) + 1;
  localparam int DW    = $clog2(DEPTH + 1);
  localparam int CMPW  = (DW > LIMIT_W) ? DW : LIMIT_W;
  localparam int KW    = $clog2(MAX_CHUNK + 1);
  localparam int LIM_RST = (DEPTH < 4096) ? DEPTH : 4096;
  localparam int CHK_RST = (MAX_CHUNK < 64) ? MAX_CHUNK : 64;

  function automatic logic [AW-1:0] ring_wrap(input logic [SW-1:0] s);
    if (s >= SW'(DEPTH)) begin
      return AW'(s - SW'(DEPTH));
    end
    return AW'(s);
  endfunction

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rd_q;

  logic [CMD_W-1:0]           cmd_q;
  logic signed [SAMPLE_W-1:0] smp_q;

  logic [AW-1:0]      rp_q, wp_q, ra_q;
  logic [KW-1:0]      k_q;
  logic [FILL_W-1:0]  fill_q;
  logic [TOTAL_W-1:0] pushed_q, dropped_q;
  logic [SAMPLE_W-1:0] peak_q;
  logic [LIMIT_W-1:0] lim_q;
  logic [CHUNK_W-1:0] chunk_q;

  logic                out_valid_q, out_kind_q, out_ok_q, out_last_q;
  logic [SAMPLE_W-1:0] out_smp_q, out_peak_q;
  logic [FILL_W-1:0]   out_fill_q;
  logic [TOTAL_W-1:0]  out_pushed_q, out_dropped_q;

  logic                full;
  logic [FILL_W-1:0]   drop;
  logic [SAMPLE_W-1:0] mag;
  logic [AW-1:0]       ra_next;
  logic [LIMIT_W-1:0]  lim_eff;
  logic [CHUNK_W-1:0]  chunk_eff;
  logic                out_load;

  // Push arithmetic: when full, drop enough oldest samples to leave room for one.
  assign full    = (fill_q >= lim_q);
  assign drop    = fill_q + FILL_W'(1) - lim_q;
  assign mag     = smp_q[SAMPLE_W-1] ? (~smp_q + SAMPLE_W'(1)) : smp_q;
  assign ra_next = ring_wrap(SW'(ra_q) + SW'(1));

  // Legalize configuration values on the way in.
  always_comb begin
    if (cfg_data_i == '0) begin
      lim_eff = LIMIT_W'(1);
    end else if (CMPW'(cfg_data_i) > CMPW'(DEPTH)) begin
      lim_eff = LIMIT_W'(DEPTH);
    end else begin
      lim_eff = cfg_data_i;
    end
    if (cfg_data_i[CHUNK_W-1:0] == '0) begin
      chunk_eff = CHUNK_W'(1);
    end else if (cfg_data_i[CHUNK_W-1:0] > CHUNK_W'(MAX_CHUNK)) begin
      chunk_eff = CHUNK_W'(MAX_CHUNK);
    end else begin
      chunk_eff = cfg_data_i[CHUNK_W-1:0];
    end
  end

  assign out_load = cmd_i.out_pop | cmd_i.out_fail | cmd_i.out_stats;

  assign sts_o.cmd_code = cmd_q;
  assign sts_o.pop_ok   = (fill_q >= FILL_W'(chunk_q));
  assign sts_o.pop_last = ((CHUNK_W'(k_q) + CHUNK_W'(1)) == chunk_q);
  assign sts_o.out_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_push) begin
      mem[wp_q] <= smp_q;
    end
    if (cmd_i.rd_issue) begin
      rd_q <= mem[ra_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q <= in_cmd_i;
      smp_q <= in_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q      <= '0;
      wp_q      <= '0;
      ra_q      <= '0;
      k_q       <= '0;
      fill_q    <= '0;
      pushed_q  <= '0;
      dropped_q <= '0;
      peak_q    <= '0;
      lim_q     <= LIMIT_W'(LIM_RST);
      chunk_q   <= CHUNK_W'(CHK_RST);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_QUEUE_LIMIT: lim_q   <= lim_eff;
          REG_CHUNK_LEN:   chunk_q <= chunk_eff;
          default: ;
        endcase
      end
      if (cmd_i.do_push) begin
        wp_q     <= ring_wrap(SW'(wp_q) + SW'(1));
        pushed_q <= pushed_q + TOTAL_W'(1);
        if (mag > peak_q) begin
          peak_q <= mag;
        end
        if (full) begin
          rp_q      <= ring_wrap(SW'(rp_q) + SW'(drop));
          fill_q    <= lim_q;
          dropped_q <= dropped_q + TOTAL_W'(drop);
        end else begin
          fill_q <= fill_q + FILL_W'(1);
        end
      end
      if (cmd_i.pop_start) begin
        ra_q <= rp_q;
        k_q  <= '0;
      end
      if (cmd_i.out_pop) begin
        ra_q <= ra_next;
        k_q  <= k_q + KW'(1);
      end
      if (cmd_i.pop_done) begin
        rp_q   <= ra_next;
        fill_q <= fill_q - FILL_W'(chunk_q);
      end
      if (cmd_i.out_stats) begin
        peak_q <= '0;
      end
    end
  end

  // Output register: holds one word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q    <= cmd_i.out_stats ? KIND_STATS : KIND_POP;
      out_ok_q      <= ~cmd_i.out_fail;
      out_last_q    <= cmd_i.out_pop ? sts_o.pop_last : 1'b1;
      out_smp_q     <= cmd_i.out_pop ? rd_q : '0;
      out_fill_q    <= cmd_i.out_stats ? fill_q : '0;
      out_pushed_q  <= cmd_i.out_stats ? pushed_q : '0;
      out_dropped_q <= cmd_i.out_stats ? dropped_q : '0;
      out_peak_q    <= cmd_i.out_stats ? peak_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {2'b00, out_peak_q, out_dropped_q, out_pushed_q, out_fill_q,
                        out_smp_q, out_ok_q};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(fill_q) <= CMPW'(DEPTH))
    else $error("fill count beyond ring depth");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_push |=> fill_q != '0)
    else $error("queue empty right after a push");

  a_stats_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_stats |=> peak_q == '0)
    else $error("peak not cleared by stats");

endmodule

// File: sv/sample_fifo_drop_oldest_peak.sv
// Top level of the audio sample queue with drop-oldest overflow and peak meter.
//
// Input words arrive on the s_axis channel: tuser carries the command (push,
// pop chunk, take stats) and tdata the signed 16-bit sample used by a push.
// A push stores the sample in a ring; when the queue already holds the limit,
// the oldest samples are discarded and counted as dropped. A pop emits exactly
// chunk_len samples in order with tlast on the final one, or a single word with
// ok clear when too few are queued. A stats request returns the fill, the pushed
// and dropped totals and the peak, then clears the peak.
// Sequencing: the block works on one word at a time and takes a new one only
// when idle. A pop moves each sample through the single registered read port
// of the ring and then into the output register, one read step and one output
// step per sample.
// Results leave through an output register, so the next word can be accepted
// while a result waits; when m_axis stalls, the sequencer waits before loading
// its next result. Reset empties the queue, clears all totals and the peak and
// restores queue_limit 4096 and chunk_len 64; ring contents are not cleared.
// Configuration writes on the cfg channel are always accepted.
module sample_fifo_drop_oldest_peak
  import sfdop_pkg::*;
#(
  parameter int DEPTH     = 4096,
  parameter int MAX_CHUNK = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SAMPLE_W-1:0]     s_axis_tdata,  // [15:0] sample_in
  input  logic [CMD_W-1:0]        s_axis_tuser,  // [1:0] cmd
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] ok, [16:1] sample_out, [29:17] queued_count, [61:30] pushed_count,
  // [93:62] dropped_count, [109:94] peak_level, [111:110] zero
  output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                    m_axis_tuser,  // [0] kind
  output logic                    m_axis_tlast,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DAT_W-1:0]    cfg_data_i
);

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  // Registers are plain flops, so a write completes in the cycle it is offered.
  assign cfg_ready_o = 1'b1;

  sfdop_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (dp_sts),
    .cmd_o         (ctrl_cmd)
  );

  sfdop_dpath #(
    .DEPTH     (DEPTH),
    .MAX_CHUNK (MAX_CHUNK)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_cmd_i    (s_axis_tuser),
    .in_sample_i (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_data_o  (m_axis_tdata)
  );

endmodule
